FILE: rtl/gfs_pkg.sv
// Shared types, constants and helpers for the Gaussian FIR smoother.
package gfs_pkg;

    localparam int TAPS       = 5;
    localparam int LEFT_REACH = TAPS / 2;
    localparam int RIGHT      = TAPS - 1 - LEFT_REACH;
    localparam int FLUSH_W    = (RIGHT > 0) ? $clog2(RIGHT + 1) : 1;

    localparam int NCOEF      = 8;
    localparam int NCOEF_W    = $clog2(NCOEF);
    localparam int PADDR_W    = $clog2(NCOEF * 4);
    localparam int PDATA_W    = 32;

    localparam int SAMP_W     = 16;
    localparam int COEF_W     = 16;
    localparam int FILL_W     = 5;
    localparam int PROD_W     = SAMP_W + COEF_W;
    localparam int MULT_W     = PROD_W + 1;
    localparam int LEVELS     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int NLEAF      = 1 << LEVELS;
    localparam int ACC_W      = PROD_W + LEVELS + 1;
    localparam int FRAC       = 14;

    localparam logic signed [ACC_W-1:0] ROUND   = ACC_W'(1 << (FRAC - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (SAMP_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    localparam logic [COEF_W-1:0] COEF_RESET [NCOEF] = '{
        16'd6536, 16'd3964, 16'd885, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
    };

    typedef struct packed {
        logic signed [SAMP_W-1:0] sample;
        logic                     end_of_vector;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMP_W-1:0] smoothed;
        logic                     clipped;
        logic                     final_result;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic fill;
        logic prod_en;
    } t_cell_ctrl;

    // Coefficient slot used by window tap j; even kernels pair the two middle taps.
    function automatic logic [NCOEF_W-1:0] tap_distance(input int j);
        int d;
        begin
            if (j < LEFT_REACH) begin
                d = LEFT_REACH - j - (((TAPS % 2) == 1) ? 0 : 1);
            end else begin
                d = j - LEFT_REACH;
            end
            return NCOEF_W'(d);
        end
    endfunction

endpackage

FILE: rtl/gfs_cell.sv
// One window tap: holds a sample, passes it to its neighbor, registers its weighted product.
module gfs_cell (
    input  logic                                 i_clk,
    input  gfs_pkg::t_cell_ctrl                  i_ctrl,
    input  logic signed [gfs_pkg::SAMP_W-1:0]    i_next,
    input  logic signed [gfs_pkg::SAMP_W-1:0]    i_fill_val,
    input  logic        [gfs_pkg::COEF_W-1:0]    i_coef,
    output logic signed [gfs_pkg::SAMP_W-1:0]    o_samp,
    output logic signed [gfs_pkg::PROD_W-1:0]    o_prod
);

    logic signed [gfs_pkg::SAMP_W-1:0] r_samp;
    logic signed [gfs_pkg::PROD_W-1:0] r_prod;
    logic signed [gfs_pkg::MULT_W-1:0] w_mult;

    assign w_mult = $signed({1'b0, i_coef}) * r_samp;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fill) begin
            r_samp <= i_fill_val;
        end else if (i_ctrl.shift) begin
            r_samp <= i_next;
        end
        if (i_ctrl.prod_en) begin
            r_prod <= w_mult[gfs_pkg::PROD_W-1:0];
        end
    end

    assign o_samp = r_samp;
    assign o_prod = r_prod;

endmodule

FILE: rtl/gfs_adder_tree.sv
// Registered binary adder tree over the tap products, then round, shift and saturate.
module gfs_adder_tree (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 i_final,
    output logic                                 o_ready,
    input  logic signed [gfs_pkg::PROD_W-1:0]    i_prod [gfs_pkg::TAPS],
    output logic                                 o_valid,
    output gfs_pkg::t_out_item                   o_item,
    input  logic                                 i_ready
);

    localparam int NLEAF  = gfs_pkg::NLEAF;
    localparam int LEVELS = gfs_pkg::LEVELS;
    localparam int ACC_W  = gfs_pkg::ACC_W;

    logic signed [ACC_W-1:0] r_node [1:NLEAF-1];
    logic signed [ACC_W-1:0] w_val  [1:2*NLEAF-1];
    logic                    r_v    [1:LEVELS];
    logic                    r_f    [1:LEVELS];
    logic                    w_en   [1:LEVELS+1];

    logic                    r_ov;
    gfs_pkg::t_out_item      r_out;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [ACC_W-1:0] w_q;
    gfs_pkg::t_out_item      w_out;

    genvar g, m;
    generate
        for (g = 0; g < NLEAF; g++) begin : g_leaf
            if (g < gfs_pkg::TAPS) begin : g_used
                assign w_val[NLEAF+g] = ACC_W'(i_prod[g]);
            end else begin : g_pad
                assign w_val[NLEAF+g] = '0;
            end
        end
        for (g = 1; g < NLEAF; g++) begin : g_inner
            assign w_val[g] = r_node[g];
        end
        for (g = 1; g <= LEVELS; g++) begin : g_level
            for (m = 0; m < (NLEAF >> g); m++) begin : g_node
                always_ff @(posedge i_clk) begin
                    if (w_en[g]) begin
                        r_node[(NLEAF >> g) + m] <= w_val[2*((NLEAF >> g) + m)]
                                                  + w_val[2*((NLEAF >> g) + m) + 1];
                    end
                end
            end
            assign w_en[g] = !r_v[g] || w_en[g+1];
            if (g == 1) begin : g_head
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[g] <= 1'b0;
                        r_f[g] <= 1'b0;
                    end else if (w_en[g]) begin
                        r_v[g] <= i_valid;
                        r_f[g] <= i_final;
                    end
                end
            end else begin : g_body
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[g] <= 1'b0;
                        r_f[g] <= 1'b0;
                    end else if (w_en[g]) begin
                        r_v[g] <= r_v[g-1];
                        r_f[g] <= r_f[g-1];
                    end
                end
            end
        end
    endgenerate

    assign w_en[LEVELS+1] = !r_ov || i_ready;
    assign o_ready        = w_en[1];

    // Round half up, then floor shift keeps the sign.
    always_comb begin
        w_rnd = r_node[1] + gfs_pkg::ROUND;
        w_q   = w_rnd >>> gfs_pkg::FRAC;
        w_out.final_result = r_f[LEVELS];
        if (w_q > gfs_pkg::SAT_MAX) begin
            w_out.smoothed = gfs_pkg::SAT_MAX[gfs_pkg::SAMP_W-1:0];
            w_out.clipped  = 1'b1;
        end else if (w_q < gfs_pkg::SAT_MIN) begin
            w_out.smoothed = gfs_pkg::SAT_MIN[gfs_pkg::SAMP_W-1:0];
            w_out.clipped  = 1'b1;
        end else begin
            w_out.smoothed = w_q[gfs_pkg::SAMP_W-1:0];
            w_out.clipped  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en[LEVELS+1]) begin
            r_ov <= r_v[LEVELS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[LEVELS+1]) begin
            r_out <= w_out;
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

endmodule

FILE: rtl/gaussian_fir_smoother_edge_replicate_core.sv
// Top level: APB coefficients, edge-replicating sample sequencer, tap chain and adder tree.
//
// Streams signed 16-bit samples through a symmetric TAPS-tap smoothing kernel.
// Input channel: i_in_valid / o_in_ready carrying i_in_data (sample, end_of_vector).
// Output channel: o_out_valid / i_out_ready carrying o_out_data (smoothed,
// clipped, final_result). Each vector yields exactly one output per sample.
// The first sample of a vector fills the whole window; outputs begin once
// RIGHT = TAPS-1-TAPS/2 samples follow it. The request carrying end_of_vector
// starts a flush of RIGHT extra pushes of the last sample, one a cycle while the
// pipeline is not stalled; o_in_ready is low during the flush, and the last
// output carries final_result. A push that forms a result passes through the
// window register, the tap product registers, one register per adder tree
// level and the round/saturate register. Throughput: one sample per cycle while
// the receiver does not stall, plus a flush of RIGHT pushes per vector.
// A stalled receiver backs the pipeline up stage by stage; bubbles collapse
// before input is held off. Reset clears the pipeline and vector state and
// loads the default coefficients. Coefficients are written over APB; the user
// must do so only while idle, unenforced by the block. coef_d lives at byte address 4*d.
module gaussian_fir_smoother_edge_replicate_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  gfs_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output gfs_pkg::t_out_item                o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gfs_pkg::PADDR_W-1:0]       paddr,
    input  logic [gfs_pkg::PDATA_W-1:0]       pwdata,
    output logic [gfs_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int TAPS = gfs_pkg::TAPS;

    logic [gfs_pkg::COEF_W-1:0]  r_coef [gfs_pkg::NCOEF];
    logic [gfs_pkg::NCOEF_W-1:0] w_idx;

    logic                        r_in_vec;
    logic [gfs_pkg::FILL_W-1:0]  r_fill;
    logic [gfs_pkg::FLUSH_W-1:0] r_flush;
    logic                        r_wv;
    logic                        r_wf;
    logic                        r_pv;
    logic                        r_pf;

    logic                        w_front_ok;
    logic                        w_acc;
    logic                        w_fl_fire;
    logic                        w_fire;
    logic                        w_start;
    logic [gfs_pkg::FILL_W-1:0]  w_fill_step;
    logic                        w_emit;
    logic                        w_final;
    logic                        w_en_p;
    logic                        w_tree_ready;
    logic signed [gfs_pkg::SAMP_W-1:0] w_push;
    gfs_pkg::t_cell_ctrl         w_ctrl;

    logic signed [gfs_pkg::SAMP_W-1:0] w_samp [TAPS];
    logic signed [gfs_pkg::PROD_W-1:0] w_prod [TAPS];

    // Configuration port
    assign pready = 1'b1;
    assign w_idx  = paddr[gfs_pkg::PADDR_W-1:2];
    assign prdata = gfs_pkg::PDATA_W'(r_coef[w_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= gfs_pkg::COEF_RESET;
        end else if (psel && penable && pwrite) begin
            r_coef[w_idx] <= pwdata[gfs_pkg::COEF_W-1:0];
        end
    end

    // Front sequencer: one window push per cycle unless stalled, from input or from the flush
    assign w_front_ok = !r_wv || w_en_p;
    assign o_in_ready = (r_flush == '0) && w_front_ok;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_fl_fire  = (r_flush != '0) && w_front_ok;
    assign w_fire     = w_acc || w_fl_fire;
    assign w_start    = w_acc && !r_in_vec;
    assign w_push     = w_fl_fire ? w_samp[TAPS-1] : i_in_data.sample;

    always_comb begin
        if (w_start) begin
            w_fill_step = '0;
        end else if (r_fill == '1) begin
            w_fill_step = r_fill;
        end else begin
            w_fill_step = r_fill + 1'b1;
        end
        w_emit  = w_fire && (w_fill_step >= gfs_pkg::FILL_W'(gfs_pkg::RIGHT));
        w_final = (w_fl_fire && (r_flush == gfs_pkg::FLUSH_W'(1)))
               || (w_acc && i_in_data.end_of_vector && (gfs_pkg::RIGHT == 0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vec <= 1'b0;
            r_fill   <= '0;
            r_flush  <= '0;
        end else if (w_fire) begin
            if (w_final) begin
                r_in_vec <= 1'b0;
                r_fill   <= '0;
                r_flush  <= '0;
            end else begin
                r_in_vec <= 1'b1;
                r_fill   <= w_fill_step;
                if (w_acc && i_in_data.end_of_vector) begin
                    r_flush <= gfs_pkg::FLUSH_W'(gfs_pkg::RIGHT);
                end else if (w_fl_fire) begin
                    r_flush <= r_flush - 1'b1;
                end
            end
        end
    end

    // Window stage holds an emit request until the products take it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
            r_wf <= 1'b0;
            r_pv <= 1'b0;
            r_pf <= 1'b0;
        end else begin
            if (w_fire) begin
                r_wv <= w_emit;
                r_wf <= w_final;
            end else if (w_en_p) begin
                r_wv <= 1'b0;
            end
            if (w_en_p) begin
                r_pv <= r_wv;
                r_pf <= r_wf;
            end
        end
    end

    assign w_en_p = !r_pv || w_tree_ready;

    assign w_ctrl.shift   = w_fire && !w_start;
    assign w_ctrl.fill    = w_start;
    assign w_ctrl.prod_en = w_en_p;

    genvar g;
    generate
        for (g = 0; g < TAPS; g++) begin : g_tap
            logic signed [gfs_pkg::SAMP_W-1:0] w_next;
            if (g == TAPS - 1) begin : g_tail
                assign w_next = w_push;
            end else begin : g_mid
                assign w_next = w_samp[g+1];
            end
            gfs_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_next     (w_next),
                .i_fill_val (i_in_data.sample),
                .i_coef     (r_coef[gfs_pkg::tap_distance(g)]),
                .o_samp     (w_samp[g]),
                .o_prod     (w_prod[g])
            );
        end
    endgenerate

    gfs_adder_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_pv),
        .i_final (r_pf),
        .o_ready (w_tree_ready),
        .i_prod  (w_prod),
        .o_valid (o_out_valid),
        .o_item  (o_out_data),
        .i_ready (i_out_ready)
    );

`ifndef ASSERT_OFF
    a_flush_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush != '0) |-> !o_in_ready)
        else $error("input accepted during end-of-vector flush");

    a_window_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wv && !w_en_p) |=> $stable(w_samp[TAPS-1]) && r_wv)
        else $error("window changed while its emit request was stalled");

    a_final_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_final) |=> (!r_in_vec && (r_flush == '0) && r_wf && r_wv))
        else $error("final result did not close the vector");
`endif

endmodule
